### src/thermistor_lut_linearizer_assert.svh
// ----------------------------------------------------------------------------
// Thermistor linearizer assertion macros
// Shared property forms for the port checker, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_LUT_LINEARIZER_ASSERT_SVH
`define THERMISTOR_LUT_LINEARIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define TLL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor linearizer package
// Widths, codes, constants and shared types for the thermistor
// piecewise-linear lookup block.
// ----------------------------------------------------------------------------
package tll_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 19;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Field widths
  localparam int ADC_W    = 10;
  localparam int ENTRY_W  = 5;
  localparam int RES_W    = 16;
  localparam int DEG_W    = 8;
  localparam int TEMP_W   = 12;
  localparam int FAULT_W  = 4;
  localparam int RATIO_W  = 6;

  // Stream and configuration widths
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // Serial arithmetic widths
  localparam int DIV_NUM_W  = 24;
  localparam int DIV_DEN_W  = 16;
  localparam int DIV_LEN_W  = 5;
  localparam int MUL_MC_W   = 16;
  localparam int MUL_MP_W   = 8;
  localparam int MUL_LEN_W  = 4;
  localparam int MUL_PROD_W = 24;

  // Conversion constants
  localparam int FULL_SCALE  = 1024;
  localparam int D_DIVISOR   = 10;
  localparam int SHORT_LIMIT = 102;
  localparam int OPEN_FAULT  = 6;
  localparam int OPEN_MAX    = 9;
  localparam int SHORT_MAX   = 5;
  localparam int RATIO_RESET = 22;

  // Command codes carried in tuser
  localparam logic CMD_CONVERT = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_RATIO = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_CLAMP     = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_D_DIV,
    S_R_MUL,
    S_R_DIV,
    S_CLAMP,
    S_SCAN,
    S_Q_MUL,
    S_Q_DIV,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic [DEG_W-1:0] deg;
  } entry_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_LEN_W-1:0] len;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [MUL_MC_W-1:0]  mcand;
    logic [MUL_MP_W-1:0]  mplier;
    logic [MUL_LEN_W-1:0] len;
  } mul_req_t;

  typedef struct packed {
    logic                  done;
    logic [MUL_PROD_W-1:0] prod;
  } mul_rsp_t;

  // Multiply by ten with two shifts and an add
  function automatic logic [TEMP_W-1:0] times_ten(input logic [TEMP_W-1:0] v);
    return TEMP_W'((v << 3) + (v << 1));
  endfunction

endpackage

### src/tll_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor table memory
// Resistance/degree pairs, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tll_table
  import tll_pkg::*;
(
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  entry_t           wr_entry_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output entry_t           rd_entry_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q;

  // Write one entry per load transfer
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_q;

endmodule

### src/tll_div_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor bit-serial divider
// Restoring division, one quotient bit per cycle. The numerator is given
// top-aligned and len bits of it are consumed.
// ----------------------------------------------------------------------------
module tll_div_serial
  import tll_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_NUM_W-1:0] work_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_LEN_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // Shift in the next numerator bit and try the subtract
  assign trial = {rem_q, work_q[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.len;
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_LEN_W'(1);
      if (cnt_q == DIV_LEN_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q <= req_i.num;
      rem_q  <= '0;
      den_q  <= req_i.den;
    end else if (busy_q) begin
      work_q <= {work_q[DIV_NUM_W-2:0], ge};
      rem_q  <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = work_q;

endmodule

### src/tll_mul_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor bit-serial multiplier
// Shift-and-add, one multiplier bit per cycle, least significant first.
// ----------------------------------------------------------------------------
module tll_mul_serial
  import tll_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic [MUL_PROD_W-1:0] acc_q;
  logic [MUL_PROD_W-1:0] mc_q;
  logic [MUL_MP_W-1:0]   mp_q;
  logic [MUL_LEN_W-1:0]  cnt_q;
  logic                  busy_q;
  logic                  done_q;

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.len;
    end else if (busy_q) begin
      cnt_q <= cnt_q - MUL_LEN_W'(1);
      if (cnt_q == MUL_LEN_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Accumulate the shifted multiplicand where the multiplier bit is set
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      mc_q  <= MUL_PROD_W'(req_i.mcand);
      mp_q  <= req_i.mplier;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= {mc_q[MUL_PROD_W-2:0], 1'b0};
      mp_q <= {1'b0, mp_q[MUL_MP_W-1:1]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

### src/thermistor_lut_linearizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor piecewise-linear linearizer
// Table load and sample conversion with open/short sensor detection.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser selects the command. A load transfer writes one
//   resistance/degree pair (an index past the table end writes nothing) with no
//   result; a convert transfer yields exactly one result on the output stream.
//   Configuration: always ready; write only while no conversion is in flight.
//   Conversion time depends on the path taken: an open or shorted input, the
//   hot clamp, a match at entry 0, a match at a later entry i, or no match.
//   The bit-serial divider (11, 16 and 24 steps), multiplier (6 and 8 steps)
//   and one table read per scanned entry do the work. One conversion is in
//   work at a time and the next input is taken the cycle after its result is
//   registered.
//   The output register holds a result until it is taken; the next result
//   waits in the finish state while the receiver stalls.
//   Reset clears fault count, temperature, output valid and configuration
//   (ratio 22, clamp off). The table is not cleared and must be loaded.
// ----------------------------------------------------------------------------
module thermistor_lut_linearizer
  import tll_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [9:0] adc_code, [14:10] entry_index, [30:15] entry_resistance,
  // [38:31] entry_degrees, [39] zero
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // [0] command
  input  logic                  s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [11:0] temperature_tenths, [15:12] fault_status
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // [0] updated
  output logic                  m_axis_tuser,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int D_NUM_W = 11;
  localparam int D_W     = 7;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Input field views
  logic [ADC_W-1:0]   in_adc;
  logic [ENTRY_W-1:0] in_index;
  entry_t             in_entry;

  assign in_adc       = s_axis_tdata[9:0];
  assign in_index     = s_axis_tdata[14:10];
  assign in_entry.res = s_axis_tdata[30:15];
  assign in_entry.deg = s_axis_tdata[38:31];

  state_e state_q, state_d;

  logic [RATIO_W-1:0] ratio_q;
  logic               clamp_q;
  logic [FAULT_W-1:0] fault_q;
  logic [TEMP_W-1:0]  temp_q;
  logic               upd_q;

  logic [ADC_W-1:0]     adc_q;
  logic [D_W-1:0]       d_q;
  logic [RES_W-1:0]     r_q;
  logic [IDX_W-1:0]     idx_q;
  logic [RES_W-1:0]     rprev_q;
  logic [DEG_W-1:0]     tprev_q;
  logic [DEG_W-1:0]     ti_q;
  logic                 neg_q;
  logic [DIV_DEN_W-1:0] den_q;

  logic               m_valid_q;
  logic [TEMP_W-1:0]  out_temp_q;
  logic [FAULT_W-1:0] out_fault_q;
  logic               out_upd_q;

  logic       in_xfer;
  logic       out_free;
  logic       wr_en;
  logic       rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t     rd_entry;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  mul_req_t   mul_req;
  mul_rsp_t   mul_rsp;

  logic             open_w;
  logic             short_w;
  logic             clamp_hit;
  logic             match;
  logic             at_first;
  logic             at_last;
  logic [DEG_W:0]   dt;
  logic [DEG_W-1:0] dt_mag;
  logic [DEG_W-1:0] qm;
  logic [TEMP_W-1:0] interp_deg;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign wr_en         = in_xfer && (s_axis_tuser == CMD_LOAD)
                         && (32'(in_index) < TABLE_DEPTH);

  // Decisions on the serial results and the table entry just read
  assign open_w    = (div_rsp.quo == '0);
  assign short_w   = (div_rsp.quo >= DIV_NUM_W'(SHORT_LIMIT));
  assign clamp_hit = clamp_q && (r_q < rd_entry.res);
  assign match     = (r_q >= rd_entry.res);
  assign at_first  = (idx_q == '0);
  assign at_last   = (idx_q == LAST_IDX);

  // Degree step to the previous entry as sign and magnitude
  assign dt     = {1'b0, rd_entry.deg} - {1'b0, tprev_q};
  assign dt_mag = dt[DEG_W] ? DEG_W'(-dt) : dt[DEG_W-1:0];
  assign qm     = div_rsp.quo[DEG_W-1:0];
  assign interp_deg = neg_q ? (TEMP_W'(ti_q) + TEMP_W'(qm))
                            : (TEMP_W'(ti_q) - TEMP_W'(qm));

  tll_table u_table (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (IDX_W'(in_index)),
    .wr_entry_i (in_entry),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry)
  );

  tll_div_serial u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tll_mul_serial u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && (s_axis_tuser == CMD_CONVERT)) state_d = S_D_DIV;
      end
      S_D_DIV: begin
        if (div_rsp.done) state_d = (open_w || short_w) ? S_FINISH : S_R_MUL;
      end
      S_R_MUL: begin
        if (mul_rsp.done) state_d = S_R_DIV;
      end
      S_R_DIV: begin
        if (div_rsp.done) state_d = S_CLAMP;
      end
      S_CLAMP: begin
        state_d = clamp_hit ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (match) state_d = at_first ? S_FINISH : S_Q_MUL;
        else if (at_last) state_d = S_FINISH;
      end
      S_Q_MUL: begin
        if (mul_rsp.done) state_d = S_Q_DIV;
      end
      S_Q_DIV: begin
        if (div_rsp.done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Unit requests and table reads
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q;
    div_req = '0;
    mul_req = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && (s_axis_tuser == CMD_CONVERT)) begin
          div_req.start = 1'b1;
          div_req.num   = {D_NUM_W'(FULL_SCALE) - D_NUM_W'(in_adc),
                           (DIV_NUM_W - D_NUM_W)'(0)};
          div_req.den   = DIV_DEN_W'(D_DIVISOR);
          div_req.len   = DIV_LEN_W'(D_NUM_W);
        end
      end
      S_D_DIV: begin
        if (div_rsp.done && !open_w && !short_w) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = MUL_MC_W'(adc_q);
          mul_req.mplier = MUL_MP_W'(ratio_q);
          mul_req.len    = MUL_LEN_W'(RATIO_W);
        end
      end
      S_R_MUL: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = {mul_rsp.prod[RES_W-1:0], (DIV_NUM_W - RES_W)'(0)};
          div_req.den   = DIV_DEN_W'(d_q);
          div_req.len   = DIV_LEN_W'(RES_W);
        end
      end
      S_R_DIV: begin
        if (div_rsp.done) begin
          rd_en   = 1'b1;
          rd_addr = LAST_IDX;
        end
      end
      S_CLAMP: begin
        if (!clamp_hit) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      S_SCAN: begin
        if (!match && !at_last) begin
          rd_en   = 1'b1;
          rd_addr = idx_q + IDX_W'(1);
        end
        if (match && !at_first) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = r_q - rd_entry.res;
          mul_req.mplier = dt_mag;
          mul_req.len    = MUL_LEN_W'(DEG_W);
        end
      end
      S_Q_MUL: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = mul_rsp.prod;
          div_req.den   = den_q;
          div_req.len   = DIV_LEN_W'(DIV_NUM_W);
        end
      end
      default: ;
    endcase
  end

  // State, configuration, fault count, temperature and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ratio_q   <= RATIO_W'(RATIO_RESET);
      clamp_q   <= 1'b0;
      fault_q   <= '0;
      temp_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Configuration writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DIVIDER_RATIO: ratio_q <= cfg_data_i[RATIO_W-1:0];
          CFG_HOT_CLAMP:     clamp_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      // Fault count and temperature updates at each decision point
      case (state_q)
        S_D_DIV: begin
          if (div_rsp.done && open_w) begin
            if (fault_q < FAULT_W'(OPEN_FAULT)) fault_q <= FAULT_W'(OPEN_FAULT);
            else if (fault_q < FAULT_W'(OPEN_MAX)) fault_q <= fault_q + FAULT_W'(1);
          end else if (div_rsp.done && short_w) begin
            if (fault_q < FAULT_W'(SHORT_MAX)) fault_q <= fault_q + FAULT_W'(1);
          end
        end
        S_CLAMP: begin
          if (clamp_hit) temp_q <= times_ten(TEMP_W'(rd_entry.deg));
        end
        S_SCAN: begin
          if (match && at_first) begin
            temp_q  <= times_ten(TEMP_W'(rd_entry.deg));
            fault_q <= '0;
          end
        end
        S_Q_DIV: begin
          if (div_rsp.done) begin
            temp_q  <= times_ten(interp_deg);
            fault_q <= '0;
          end
        end
        default: ;
      endcase

      // Output register handshake
      if (state_q == S_FINISH && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the conversion
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        adc_q <= in_adc;
        upd_q <= 1'b0;
      end
      S_D_DIV: begin
        if (div_rsp.done) d_q <= div_rsp.quo[D_W-1:0];
      end
      S_R_DIV: begin
        if (div_rsp.done) r_q <= div_rsp.quo[RES_W-1:0];
      end
      S_CLAMP: begin
        idx_q <= '0;
        if (clamp_hit) upd_q <= 1'b1;
      end
      S_SCAN: begin
        if (match) begin
          ti_q  <= rd_entry.deg;
          neg_q <= dt[DEG_W];
          den_q <= rprev_q - rd_entry.res;
          upd_q <= 1'b1;
        end else begin
          rprev_q <= rd_entry.res;
          tprev_q <= rd_entry.deg;
          idx_q   <= idx_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Capture the result into the output register
  always_ff @(posedge clk_i) begin
    if (state_q == S_FINISH && out_free) begin
      out_temp_q  <= temp_q;
      out_fault_q <= fault_q;
      out_upd_q   <= upd_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_fault_q, out_temp_q};
  assign m_axis_tuser  = out_upd_q;

endmodule

### src/tll_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor linearizer port checker
// Watches the top-level ports for stream and sequencing rules.
// ----------------------------------------------------------------------------
`include "thermistor_lut_linearizer_assert.svh"

module tll_checker
  import tll_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic                 s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata
);

  // Hold a result until the receiver takes it
  `TLL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

  // Keep the fault count within its open-sensor ceiling
  `TLL_ASSERT_SAME(a_fault_range, m_axis_tvalid, m_axis_tdata[15:12] <= FAULT_W'(OPEN_MAX), "fault status out of range")

  // Stop taking inputs once a conversion transfer is in
  `TLL_ASSERT_NEXT(a_convert_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_CONVERT), !s_axis_tready, "input taken during conversion")

  // Take the next transfer straight after a table load
  `TLL_ASSERT_NEXT(a_load_ready, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOAD), s_axis_tready, "not ready after table load")

endmodule

bind thermistor_lut_linearizer tll_checker u_tll_checker (.*);

### verif/thermistor_lut_linearizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor linearizer testbench
// Loads resistance/degree tables over the input stream and converts a short
// directed sequence, then random samples under several register settings.
// Every output transfer is compared field by field with a behavioural model
// of the conversion or a fixed expected reading; sender gaps and receiver stalls are off in some phases.
// ----------------------------------------------------------------------------
module thermistor_lut_linearizer_tb;
  import tll_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 3;
  localparam int SETTLE_CYCLES = 120;
  localparam int IDLE_LIMIT    = 3000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int REPORT_MAX    = 10;

  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = '1;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp;
    logic               upd;
    logic [FAULT_W-1:0] fault;
  } reading_t;

  typedef enum logic {ROW_XFER, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic                  cmd;
    logic [ADC_W-1:0]      adc;
    logic [ENTRY_W-1:0]    idx;
    logic [RES_W-1:0]      res;
    logic [DEG_W-1:0]      deg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  typed;
    reading_t              want;
  } stim_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = CMD_CONVERT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Model state of the block
  logic [RES_W-1:0]   mdl_res [TABLE_DEPTH];
  logic [DEG_W-1:0]   mdl_deg [TABLE_DEPTH];
  logic [FAULT_W-1:0] mdl_fault;
  logic [TEMP_W-1:0]  mdl_temp;
  logic [RATIO_W-1:0] mdl_ratio;
  logic               mdl_clamp;

  // Next table to load
  logic [RES_W-1:0] plan_res [TABLE_DEPTH];
  logic [DEG_W-1:0] plan_deg [TABLE_DEPTH];

  reading_t  pending_readings [$];
  stim_row_t directed_rows [$];
  int        errors      = 0;
  int        idle_cycles = 0;
  int        burst_left  = 0;
  int        rx_run_left = 0;
  bit        tx_gaps     = 1'b1;
  bit        rx_free     = 1'b0;

  thermistor_lut_linearizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Apply one accepted input transfer to the model; a sample yields a reading
  task automatic linearize(input logic cmd, input logic [ADC_W-1:0] adc,
                           input logic [ENTRY_W-1:0] idx, input logic [RES_W-1:0] res,
                           input logic [DEG_W-1:0] deg, output bit produced,
                           output reading_t rd);
    int d, r, i, ri, rj, ti, tj, q;
    bit upd;
    produced = 1'b0;
    rd       = '0;
    upd      = 1'b0;
    if (cmd == CMD_LOAD) begin
      // write both tables, drop indexes past the end
      if (int'(idx) < TABLE_DEPTH) begin
        mdl_res[idx] = res;
        mdl_deg[idx] = deg;
      end
    end else begin
      produced = 1'b1;
      d = (FULL_SCALE - int'(adc)) / D_DIVISOR;
      if (d == 0) begin
        // open sensor: jump to the open count, then count up to its ceiling
        if (mdl_fault < OPEN_FAULT) begin
          mdl_fault = FAULT_W'(OPEN_FAULT);
        end else if (mdl_fault < OPEN_MAX) begin
          mdl_fault = mdl_fault + 1'b1;
        end
      end else if (d >= SHORT_LIMIT) begin
        // shorted sensor: count up, hold anything already at or above the ceiling
        if (mdl_fault < SHORT_MAX) begin
          mdl_fault = mdl_fault + 1'b1;
        end
      end else begin
        r = int'(adc) * int'(mdl_ratio) / d;
        if (mdl_clamp && r < int'(mdl_res[TABLE_DEPTH-1])) begin
          // hot clamp keeps the fault count
          mdl_temp = TEMP_W'(10 * int'(mdl_deg[TABLE_DEPTH-1]));
          upd      = 1'b1;
        end else begin
          i = 0;
          while (i < TABLE_DEPTH && r < int'(mdl_res[i])) begin
            i++;
          end
          if (i < TABLE_DEPTH) begin
            if (i == 0) begin
              mdl_temp = TEMP_W'(10 * int'(mdl_deg[0]));
            end else begin
              ri = int'(mdl_res[i]);
              rj = int'(mdl_res[i-1]);
              ti = int'(mdl_deg[i]);
              tj = int'(mdl_deg[i-1]);
              q  = ((r - ri) * (ti - tj)) / (rj - ri);
              mdl_temp = TEMP_W'(10 * (ti - q));
            end
            mdl_fault = '0;
            upd       = 1'b1;
          end
        end
      end
      rd.temp  = mdl_temp;
      rd.upd   = upd;
      rd.fault = mdl_fault;
    end
  endtask

  // Offer one input transfer in bursts and gaps, then record what it should yield
  task automatic send_xfer(input logic cmd, input logic [ADC_W-1:0] adc,
                           input logic [ENTRY_W-1:0] idx, input logic [RES_W-1:0] res,
                           input logic [DEG_W-1:0] deg, input bit typed,
                           input reading_t want);
    bit       produced;
    reading_t rd;
    if (tx_gaps && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 8))
        @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, deg, res, idx, adc};
    do @(posedge clk_i); while (!s_axis_tready);
    linearize(cmd, adc, idx, res, deg, produced, rd);
    if (produced) begin
      pending_readings.push_back(typed ? want : rd);
    end
  endtask

  // Hold the input until every reading is back and the block has gone quiet
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ridx,
                           input logic [CFG_DATA_W-1:0] data);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ridx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (ridx == CFG_DIVIDER_RATIO) begin
      mdl_ratio = data[RATIO_W-1:0];
    end else if (ridx == CFG_HOT_CLAMP) begin
      mdl_clamp = data[0];
    end
  endtask

  task automatic load_table();
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      send_xfer(CMD_LOAD, ADC_W'($urandom), ENTRY_W'(k), plan_res[k], plan_deg[k], 1'b0, '0);
    end
  endtask

  function automatic stim_row_t conv_row(input int adc);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_XFER;
    row.cmd  = CMD_CONVERT;
    row.adc  = ADC_W'(adc);
    return row;
  endfunction

  function automatic stim_row_t conv_typed(input int adc, input int temp, input int upd,
                                           input int fault);
    stim_row_t row;
    row            = conv_row(adc);
    row.typed      = 1'b1;
    row.want.temp  = TEMP_W'(temp);
    row.want.upd   = upd[0];
    row.want.fault = FAULT_W'(fault);
    return row;
  endfunction

  function automatic stim_row_t load_row(input int idx, input int res, input int deg);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_XFER;
    row.cmd  = CMD_LOAD;
    row.idx  = ENTRY_W'(idx);
    row.res  = RES_W'(res);
    row.deg  = DEG_W'(deg);
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] ridx, input int data);
    stim_row_t row;
    row          = '0;
    row.kind     = ROW_CFG;
    row.reg_idx  = ridx;
    row.reg_data = CFG_DATA_W'(data);
    return row;
  endfunction

  // Receiver: alternate ready and stall runs, or stay ready in free phases
  always @(posedge clk_i) begin
    if (rx_run_left == 0) begin
      if (rx_free || !m_axis_tready) begin
        m_axis_tready <= 1'b1;
        rx_run_left   <= $urandom_range(1, 24);
      end else begin
        m_axis_tready <= 1'b0;
        rx_run_left   <= $urandom_range(1, 20);
      end
    end else begin
      rx_run_left <= rx_run_left - 1;
    end
  end

  // Compare each output transfer with the oldest pending reading
  always @(posedge clk_i) begin : check_readings
    reading_t got;
    reading_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.temp  = m_axis_tdata[TEMP_W-1:0];
      got.fault = m_axis_tdata[TEMP_W +: FAULT_W];
      got.upd   = m_axis_tuser;
      if (pending_readings.size() == 0) begin
        if (errors < REPORT_MAX) begin
          $display("unexpected reading: temp %0d upd %0d fault %0d",
                   got.temp, got.upd, got.fault);
        end
        errors++;
      end else begin
        want = pending_readings.pop_front();
        if (got.temp !== want.temp || got.upd !== want.upd || got.fault !== want.fault) begin
          if (errors < REPORT_MAX) begin
            $display("reading mismatch: temp %0d/%0d upd %0d/%0d fault %0d/%0d (exp/got)",
                     want.temp, got.temp, want.upd, got.upd, want.fault, got.fault);
          end
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("thermistor_lut_linearizer_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned r_val;
    int unsigned nxt;
    int          t_val;
    int          step;
    int          sel;
    int          idx;
    int          adc;
    int          ratio;
    bit          falling;
    stim_row_t   row;

    // Model state after reset
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      mdl_res[k] = '0;
      mdl_deg[k] = '0;
    end
    mdl_fault = '0;
    mdl_temp  = '0;
    mdl_ratio = RATIO_W'(RATIO_RESET);
    mdl_clamp = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reference table: resistance falls by a third per entry, degrees rise to the top
    r_val = 60000;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      plan_res[k] = RES_W'(r_val);
      plan_deg[k] = (k == TABLE_DEPTH - 1) ? DEG_W'(255) : DEG_W'(k * 14);
      r_val       = r_val * 2 / 3;
    end
    load_table();

    // Fault counting straight after reset needs no table read
    directed_rows.push_back(conv_typed(1023, 0, 0, OPEN_FAULT));
    directed_rows.push_back(conv_typed(1015, 0, 0, OPEN_FAULT + 1));
    directed_rows.push_back(conv_typed(1020, 0, 0, OPEN_FAULT + 2));
    directed_rows.push_back(conv_typed(1023, 0, 0, OPEN_MAX));
    directed_rows.push_back(conv_typed(1023, 0, 0, OPEN_MAX));
    directed_rows.push_back(conv_typed(0, 0, 0, OPEN_MAX));
    directed_rows.push_back(conv_typed(4, 0, 0, OPEN_MAX));
    // Interpolation with the reset ratio
    directed_rows.push_back(conv_row(512));
    // Loads past the end of the table
    directed_rows.push_back(load_row(19, 0, 255));
    directed_rows.push_back(load_row(31, 65535, 255));
    // Below the table with the clamp off, then on
    directed_rows.push_back(conv_row(5));
    directed_rows.push_back(cfg_row(CFG_HOT_CLAMP, 1));
    directed_rows.push_back(conv_typed(5, 2550, 1, 0));
    // Largest resistance hits the first entry
    directed_rows.push_back(cfg_row(CFG_DIVIDER_RATIO, 63));
    directed_rows.push_back(conv_typed(1014, 0, 1, 0));
    // Zero ratio, clamp on and off; upper data bits are dropped
    directed_rows.push_back(cfg_row(CFG_DIVIDER_RATIO, 0));
    directed_rows.push_back(conv_row(600));
    directed_rows.push_back(cfg_row(CFG_HOT_CLAMP, 8'hFE));
    directed_rows.push_back(conv_row(600));
    directed_rows.push_back(cfg_row(CFG_DIVIDER_RATIO, 8'hC1));
    directed_rows.push_back(cfg_row(CFG_SPARE, 8'hFF));
    directed_rows.push_back(conv_row(900));
    // Short counting from a clean status up to its ceiling
    directed_rows.push_back(conv_row(2));
    for (int k = 0; k < 5; k++) begin
      directed_rows.push_back(conv_row(0));
    end
    // Extreme table entries
    directed_rows.push_back(load_row(0, 65535, 0));
    directed_rows.push_back(load_row(TABLE_DEPTH - 1, 0, 255));
    directed_rows.push_back(conv_row(1014));
    directed_rows.push_back(conv_row(5));

    for (int k = 0; k < directed_rows.size(); k++) begin
      row = directed_rows[k];
      if (row.kind == ROW_CFG) begin
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_xfer(row.cmd, row.adc, row.idx, row.res, row.deg, row.typed, row.want);
      end
    end

    // Random phases, each with its own settings and table
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       ratio = 1;
        1:       ratio = 63;
        2:       ratio = (ph == 3) ? 0 : RATIO_RESET;
        default: ratio = $urandom_range(1, 63);
      endcase
      write_reg(CFG_DIVIDER_RATIO, CFG_DATA_W'(($urandom_range(0, 3) << RATIO_W) | ratio));
      write_reg(CFG_HOT_CLAMP, CFG_DATA_W'(($urandom_range(0, 127) << 1) | $urandom_range(0, 1)));
      tx_gaps = (ph != 1) && ($urandom_range(0, 4) != 0);
      rx_free = (ph == 1) || ($urandom_range(0, 4) == 0);

      if ($urandom_range(0, 5) == 0) begin
        // noise table in arbitrary order
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          plan_res[k] = RES_W'($urandom);
          plan_deg[k] = DEG_W'($urandom);
        end
      end else begin
        // falling resistance on a rough log scale, degrees in either direction
        falling = $urandom_range(0, 1);
        r_val   = $urandom_range(20000, 65535);
        t_val   = falling ? $urandom_range(200, 255) : $urandom_range(0, 60);
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          plan_res[k] = RES_W'(r_val);
          plan_deg[k] = DEG_W'(t_val);
          nxt = r_val * $urandom_range(9, 14) / 16;
          if (nxt >= r_val && r_val > 0) begin
            nxt = r_val - 1;
          end
          r_val = nxt;
          step  = $urandom_range(0, 12);
          if (falling) begin
            t_val = (t_val > step) ? t_val - step : 0;
          end else begin
            t_val = (t_val + step > 255) ? 255 : t_val + step;
          end
        end
      end
      load_table();

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // now and then let the block drain completely
        if ($urandom_range(0, 99) == 0) begin
          s_axis_tvalid <= 1'b0;
          do @(posedge clk_i); while (pending_readings.size() != 0);
        end
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                            : $urandom_range(0, TABLE_DEPTH - 1);
          send_xfer(CMD_LOAD, ADC_W'($urandom), ENTRY_W'(idx), RES_W'($urandom),
                    DEG_W'($urandom), 1'b0, '0);
        end else begin
          if (sel < 10) begin
            adc = $urandom_range(1015, 1023);
          end else if (sel < 15) begin
            adc = $urandom_range(0, 4);
          end else begin
            adc = $urandom_range(5, 1014);
          end
          send_xfer(CMD_CONVERT, ADC_W'(adc), ENTRY_W'($urandom), RES_W'($urandom),
                    DEG_W'($urandom), 1'b0, '0);
        end
      end
    end

    settle_block();
    if (errors == 0) begin
      $display("thermistor_lut_linearizer_tb: done, clean");
    end else begin
      $display("thermistor_lut_linearizer_tb: done, errors");
    end
    $finish;
  end

endmodule

### thermistor_lut_linearizer.f
+incdir+src
src/tll_pkg.sv
src/tll_table.sv
src/tll_div_serial.sv
src/tll_mul_serial.sv
src/thermistor_lut_linearizer.sv
src/tll_checker.sv
verif/thermistor_lut_linearizer_tb.sv
